// ===== sv/sial_pkg.sv =====
// Package with the types and constants shared by the list modules.
`default_nettype none

package sial_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = 7;
   localparam int POS_W  = 8;
   localparam int ACT_W  = 3;
   localparam int STS_W  = 2;
   localparam int GRP_SZ = 8;

   localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd4;

   localparam logic [STS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY  = 2'd1;
   localparam logic [STS_W-1:0] STS_BOUNDS = 2'd2;
   localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [POS_W-1:0]  position;
      logic signed [WORD_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value_out;
      logic [CNT_W-1:0]         count;
      logic [STS_W-1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      COP_HOLD,
      COP_INSERT,
      COP_REMOVE,
      COP_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [CNT_W-1:0]  index;
      logic [WORD_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] index;
   } rd_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GATHER,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== sv/sial_cell.sv =====
// One storage cell of the list, holding one word and trading it with its neighbors.
`default_nettype none

module sial_cell
   import sial_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire cell_cmd_type      cmd,
   input  wire rd_cmd_type        rd,
   input  wire logic [WORD_W-1:0] below_data,
   input  wire logic [WORD_W-1:0] above_data,
   output logic [WORD_W-1:0]      data_out,
   output logic [WORD_W-1:0]      rd_data
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         COP_INSERT: begin
            if (MY_IDX > cmd.index) begin
               data_in = below_data;
            end else if (MY_IDX == cmd.index) begin
               data_in = cmd.value;
            end
         end
         COP_REMOVE: begin
            if (MY_IDX >= cmd.index) begin
               data_in = above_data;
            end
         end
         COP_WRITE: begin
            if (MY_IDX == cmd.index) begin
               data_in = cmd.value;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_data  = (rd.en && (rd.index == MY_IDX)) ? data_ff : '0;

endmodule

`default_nettype wire

// ===== sv/sial_gather.sv =====
// Registered OR tree that collects the one selected word from the cells.
`default_nettype none

module sial_gather
   import sial_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic                           clock,
   input  wire logic [CAPACITY-1:0][WORD_W-1:0] cell_data,
   output logic [WORD_W-1:0]                   word_out
);

   localparam int NGRP = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

   logic [NGRP-1:0][WORD_W-1:0] grp_ff;
   logic [NGRP-1:0][WORD_W-1:0] grp_in;

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         for (int k = 0; k < GRP_SZ; k++) begin
            if (g * GRP_SZ + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_data[g * GRP_SZ + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      word_out = '0;
      for (int g = 0; g < NGRP; g++) begin
         word_out = word_out | grp_ff[g];
      end
   end

endmodule

`default_nettype wire

// ===== sv/shift_insert_array_list.sv =====
// Top level of the ordered word list built from a row of shifting cells.
//
//   Channel   Ports                         Direction  Content
//   request   req_valid req_stall req_data  in         action, position, value_in
//   response  rsp_valid rsp_stall rsp_data  out        value_out, count, status
//
// Each transaction passes from acceptance to the response through the command
// register, the cell update with the selected word captured in the first OR-tree stage,
// and the response register. Reverse flips an orientation flag, so it takes the same
// steps. One transaction is in flight at a time; req_stall stays high until the
// response has been taken, so no new transaction is accepted before then, and rsp_stall
// on a waiting response holds off the next transaction as long as it stays high.
// Reset empties the list; the cells themselves are not cleared.
`default_nettype none

module shift_insert_array_list
   import sial_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type state_ff;
   state_type state_in;

   req_type           cmd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rev_ff;
   logic              rev_in;
   logic [STS_W-1:0]  status_ff;
   logic [STS_W-1:0]  status_in;
   rsp_type           rsp_ff;

   cell_cmd_type      cell_cmd;
   rd_cmd_type        rd_cmd;
   logic [WORD_W-1:0] gathered;

   logic [CAPACITY-1:0][WORD_W-1:0] cell_q;
   logic [CAPACITY-1:0][WORD_W-1:0] cell_rd;

   logic              req_accept;
   logic              pos_neg;
   logic [CNT_W-1:0]  pos_u;
   logic              pos_ge;
   logic [CNT_W-1:0]  lidx;

   assign req_accept = req_valid && !req_stall;
   assign pos_neg    = cmd_ff.position[POS_W-1];
   assign pos_u      = cmd_ff.position[CNT_W-1:0];
   assign pos_ge     = !pos_neg && (pos_u >= count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_GATHER;
         ST_GATHER: state_in = ST_RESP;
         ST_RESP:   if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
   end

   always_comb begin
      cell_cmd.op    = COP_HOLD;
      cell_cmd.index = '0;
      cell_cmd.value = cmd_ff.value_in;
      rd_cmd.en      = 1'b0;
      rd_cmd.index   = '0;
      count_in       = count_ff;
      rev_in         = rev_ff;
      status_in      = STS_OK;
      lidx           = '0;
      if (state_ff == ST_EXEC) begin
         unique case (cmd_ff.action) inside
            ACT_INSERT: begin
               if (count_ff >= CNT_W'(CAPACITY)) begin
                  status_in = STS_FULL;
               end else begin
                  lidx = pos_neg ? '0 : (pos_ge ? count_ff : pos_u);
                  cell_cmd.op    = COP_INSERT;
                  cell_cmd.index = rev_ff ? (count_ff - lidx) : lidx;
                  count_in       = count_ff + CNT_W'(1);
               end
            end
            ACT_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else begin
                  lidx = pos_neg ? '0 : (pos_ge ? (count_ff - CNT_W'(1)) : pos_u);
                  cell_cmd.op    = COP_REMOVE;
                  cell_cmd.index = rev_ff ? (count_ff - CNT_W'(1) - lidx) : lidx;
                  rd_cmd.en      = 1'b1;
                  rd_cmd.index   = cell_cmd.index;
                  count_in       = count_ff - CNT_W'(1);
               end
            end
            ACT_READ, ACT_WRITE: begin
               if (pos_neg || pos_ge) begin
                  status_in = STS_BOUNDS;
               end else begin
                  cell_cmd.index = rev_ff ? (count_ff - CNT_W'(1) - pos_u) : pos_u;
                  if (cmd_ff.action == ACT_READ) begin
                     rd_cmd.en    = 1'b1;
                     rd_cmd.index = cell_cmd.index;
                  end else begin
                     cell_cmd.op = COP_WRITE;
                  end
               end
            end
            ACT_REVERSE: rev_in = !rev_ff;
            default:     status_in = STS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_data;
      end
      if (state_ff == ST_EXEC) begin
         status_ff <= status_in;
      end
      if (state_ff == ST_GATHER) begin
         rsp_ff.value_out <= gathered;
         rsp_ff.count     <= count_ff;
         rsp_ff.status    <= status_ff;
      end
   end

   assign rsp_data = rsp_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] below;
      logic [WORD_W-1:0] above;
      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_mid_lo
         assign below = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign above = cell_q[i];
      end else begin : g_mid_hi
         assign above = cell_q[i+1];
      end
      sial_cell #(
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .rd         (rd_cmd),
         .below_data (below),
         .above_data (above),
         .data_out   (cell_q[i]),
         .rd_data    (cell_rd[i])
      );
   end

   sial_gather #(
      .CAPACITY(CAPACITY)
   ) u_gather (
      .clock     (clock),
      .cell_data (cell_rd),
      .word_out  (gathered)
   );

endmodule

`default_nettype wire
